// File: hdl/raw_hazard_stall_scoreboard_assert.svh
// assertion macros for the raw hazard stall scoreboard
// expects clk and rst in scope at the point of use, no other dependencies
`ifndef RAW_HAZARD_STALL_SCOREBOARD_ASSERT_SVH
`define RAW_HAZARD_STALL_SCOREBOARD_ASSERT_SVH

// same-cycle implication
`define RHSS_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("rhss check failed");

// next-cycle implication
`define RHSS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("rhss check failed");

`endif

// File: hdl/rhss_pkg.sv
// types, constants and helpers shared by the raw hazard stall scoreboard
// no dependencies
package rhss_pkg;

  localparam int REG_W      = 7;
  localparam int CLK_W      = 64;
  localparam int STALL_W    = 3;
  localparam int LAT_W      = 3;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 3;
  localparam int NUM_SRC    = 3;

  localparam logic [CFG_IDX_W-1:0] CFG_READY_P1 = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LOAD_P2  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ALU_P2   = 2'd2;

  localparam logic [LAT_W-1:0] READY_P1_RST = 3'd3;
  localparam logic [LAT_W-1:0] LOAD_P2_RST  = 3'd3;
  localparam logic [LAT_W-1:0] ALU_P2_RST   = 3'd2;

  localparam logic [STALL_W-1:0] STALL_MAX = 3'd7;
  localparam logic [CLK_W-1:0]   CLOCK_RST = 64'd1;

  typedef logic [REG_W-1:0] regno_t;
  typedef logic [CLK_W-1:0] cycle_t;

  typedef struct packed {
    regno_t src_a;
    regno_t src_b;
    regno_t src_c;
    regno_t dst_a;
    regno_t dst_b;
    logic   is_load;
    logic   is_store;
  } issue_t;

  typedef struct packed {
    logic [STALL_W-1:0] stall_p1;
    logic [STALL_W-1:0] stall_p2;
    cycle_t             clock_p1;
    cycle_t             clock_p2;
    cycle_t             hazards_p1;
    cycle_t             hazards_p2;
    cycle_t             one_cycle_p1;
    cycle_t             two_cycle_p1;
    cycle_t             one_cycle_p2;
    cycle_t             two_cycle_p2;
  } stat_t;

  typedef struct packed {
    cycle_t p1;
    cycle_t p2;
  } rdy_pair_t;

  typedef struct packed {
    logic      en;
    regno_t    regno;
    rdy_pair_t rdy;
  } wr_req_t;

  // saturated positive gap between a ready time and the current cycle
  function automatic logic [STALL_W-1:0] gap_of(cycle_t ready, cycle_t now);
    logic [CLK_W:0] diff;
    diff = {1'b0, ready} - {1'b0, now};
    if (diff[CLK_W] || (diff == '0)) begin
      return '0;
    end else if (diff[CLK_W-1:STALL_W] != '0) begin
      return STALL_MAX;
    end else begin
      return diff[STALL_W-1:0];
    end
  endfunction

endpackage

// File: hdl/rhss_ready_store.sv
// ready-time store: per-register ready times of both pipelines in block memories
// depends on rhss_pkg
module rhss_ready_store import rhss_pkg::*; #(
  parameter int NUM_REGS = 128
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      rd_en,
  input  regno_t [NUM_SRC-1:0]      src,
  input  wr_req_t                   wr,
  output rdy_pair_t [NUM_SRC-1:0]   rdy
);

  localparam int AW    = $clog2(NUM_REGS);
  localparam int DEPTH = 1 << AW;

  // two copies so three sources can be looked up at once
  rdy_pair_t mem_ab [DEPTH];
  rdy_pair_t mem_c  [DEPTH];

  logic [DEPTH-1:0]         valid;
  logic [AW-1:0]            rd_addr [NUM_SRC];
  logic [AW-1:0]            wr_addr;
  rdy_pair_t [NUM_SRC-1:0]  rd_q;
  logic [NUM_SRC-1:0]       vld_q;
  logic [NUM_SRC-1:0]       hit_q;
  rdy_pair_t                byp_q;

  always_comb begin
    for (int i = 0; i < NUM_SRC; i++) begin
      rd_addr[i] = AW'(src[i]);
    end
    wr_addr = AW'(wr.regno);
  end

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem_ab[wr_addr] <= wr.rdy;
      mem_c[wr_addr]  <= wr.rdy;
    end
    if (rd_en) begin
      rd_q[0] <= mem_ab[rd_addr[0]];
      rd_q[1] <= mem_ab[rd_addr[1]];
      rd_q[2] <= mem_c[rd_addr[2]];
      byp_q   <= wr.rdy;
      for (int i = 0; i < NUM_SRC; i++) begin
        vld_q[i] <= valid[rd_addr[i]];
        hit_q[i] <= wr.en && (wr.regno == src[i]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (wr.en) begin
      valid[wr_addr] <= 1'b1;
    end
  end

  // forward a write that lands on the same edge as the lookup
  always_comb begin
    for (int i = 0; i < NUM_SRC; i++) begin
      if (hit_q[i]) begin
        rdy[i] = byp_q;
      end else if (vld_q[i]) begin
        rdy[i] = rd_q[i];
      end else begin
        rdy[i] = '0;
      end
    end
  end

endmodule

// File: hdl/raw_hazard_stall_scoreboard.sv
// raw hazard stall scoreboard top level: stall check, cycle clocks, stall counters
// depends on rhss_pkg, rhss_ready_store and raw_hazard_stall_scoreboard_assert.svh
//
//   port group   kind          word
//   issue        valid/ready   issue_t, one decoded instruction
//   stat         valid/ready   stat_t, stalls, clocks and counters
//   cfg          write only    cfg_idx selects latency, cfg_wdata value
//
// from issue accept to stat valid: ready-time lookup, then check and update, each registered
// one word per cycle while stat words are taken; a word with two distinct destinations
// stops issue while checked, set by the single write port of the ready-time memories
// a waiting stat word holds the check stage, one more issue word is still taken
// synchronous reset: clocks to one, counters and valid bits cleared, no sweep
`include "raw_hazard_stall_scoreboard_assert.svh"

module raw_hazard_stall_scoreboard import rhss_pkg::*; #(
  parameter int NUM_REGS = 128
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  issue_valid,
  output logic                  issue_ready,
  input  issue_t                issue,
  output logic                  stat_valid,
  input  logic                  stat_ready,
  output stat_t                 stat,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_idx,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  localparam cycle_t CNEXT_RST = CLOCK_RST + CLK_W'(1);

  function automatic logic reg_used(regno_t r);
    return (r != '0) && (int'(r) < NUM_REGS);
  endfunction

  logic                    issue_fire;
  logic                    e_fire;
  logic                    s1_valid;
  issue_t                  s1;
  logic [LAT_W-1:0]        lat_p1;
  logic [LAT_W-1:0]        lat_load_p2;
  logic [LAT_W-1:0]        lat_alu_p2;
  logic [LAT_W-1:0]        lat_p2;
  cycle_t                  cnext_p1;
  cycle_t                  cnext_p2;
  cycle_t                  hz_p1;
  cycle_t                  hz_p2;
  cycle_t                  one_p1;
  cycle_t                  two_p1;
  cycle_t                  one_p2;
  cycle_t                  two_p2;
  regno_t [NUM_SRC-1:0]    rd_src;
  regno_t [NUM_SRC-1:0]    s1_src;
  rdy_pair_t [NUM_SRC-1:0] rdy;
  logic [STALL_W-1:0]      st_p1;
  logic [STALL_W-1:0]      st_p2;
  cycle_t                  rdy_p1_new;
  cycle_t                  rdy_p2_new;
  cycle_t                  cnext_p1_next;
  cycle_t                  cnext_p2_next;
  logic                    use_a;
  logic                    use_b;
  logic                    dual;
  logic                    pend_valid;
  regno_t                  pend_regno;
  rdy_pair_t               pend_rdy;
  wr_req_t                 wr;
  stat_t                   res;

  assign issue_fire = issue_valid && issue_ready;
  assign e_fire     = s1_valid && (!stat_valid || stat_ready);
  assign use_a      = reg_used(s1.dst_a);
  assign use_b      = reg_used(s1.dst_b);
  assign dual       = use_a && use_b && (s1.dst_a != s1.dst_b);
  assign issue_ready = !s1_valid || (e_fire && !dual);
  assign lat_p2     = s1.is_load ? lat_load_p2 : lat_alu_p2;
  assign rd_src     = {issue.src_c, issue.src_b, issue.src_a};
  assign s1_src     = {s1.src_c, s1.src_b, s1.src_a};

  rhss_ready_store #(
    .NUM_REGS (NUM_REGS)
  ) u_store (
    .clk   (clk),
    .rst   (rst),
    .rd_en (issue_fire),
    .src   (rd_src),
    .wr    (wr),
    .rdy   (rdy)
  );

  // worst gap over the sources, store data exempt in pipeline two
  always_comb begin
    logic [STALL_W-1:0] g1;
    logic [STALL_W-1:0] g2;
    st_p1 = '0;
    st_p2 = '0;
    for (int i = 0; i < NUM_SRC; i++) begin
      g1 = gap_of(rdy[i].p1, cnext_p1);
      g2 = gap_of(rdy[i].p2, cnext_p2);
      if (reg_used(s1_src[i])) begin
        if (g1 > st_p1) begin
          st_p1 = g1;
        end
        if (!((i == 0) && s1.is_store) && (g2 > st_p2)) begin
          st_p2 = g2;
        end
      end
    end
  end

  always_comb begin
    rdy_p1_new    = cnext_p1 + CLK_W'({1'b0, st_p1} + {1'b0, lat_p1});
    rdy_p2_new    = cnext_p2 + CLK_W'({1'b0, st_p2} + {1'b0, lat_p2});
    cnext_p1_next = cnext_p1 + CLK_W'({1'b0, st_p1} + 4'd1);
    cnext_p2_next = cnext_p2 + CLK_W'({1'b0, st_p2} + 4'd1);

    res.stall_p1     = st_p1;
    res.stall_p2     = st_p2;
    res.clock_p1     = cnext_p1 + CLK_W'(st_p1);
    res.clock_p2     = cnext_p2 + CLK_W'(st_p2);
    res.hazards_p1   = hz_p1 + CLK_W'(st_p1 != '0);
    res.hazards_p2   = hz_p2 + CLK_W'(st_p2 != '0);
    res.one_cycle_p1 = one_p1 + CLK_W'(st_p1 == 3'd1);
    res.two_cycle_p1 = two_p1 + CLK_W'(st_p1 == 3'd2);
    res.one_cycle_p2 = one_p2 + CLK_W'(st_p2 == 3'd1);
    res.two_cycle_p2 = two_p2 + CLK_W'(st_p2 == 3'd2);
  end

  // second destination goes out on the following cycle
  always_comb begin
    wr.en     = 1'b0;
    wr.regno  = s1.dst_a;
    wr.rdy.p1 = rdy_p1_new;
    wr.rdy.p2 = rdy_p2_new;
    if (pend_valid) begin
      wr.en    = 1'b1;
      wr.regno = pend_regno;
      wr.rdy   = pend_rdy;
    end else if (e_fire && (use_a || use_b)) begin
      wr.en    = 1'b1;
      wr.regno = use_a ? s1.dst_a : s1.dst_b;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid    <= 1'b0;
      stat_valid  <= 1'b0;
      pend_valid  <= 1'b0;
      cnext_p1    <= CNEXT_RST;
      cnext_p2    <= CNEXT_RST;
      hz_p1       <= '0;
      hz_p2       <= '0;
      one_p1      <= '0;
      two_p1      <= '0;
      one_p2      <= '0;
      two_p2      <= '0;
      lat_p1      <= READY_P1_RST;
      lat_load_p2 <= LOAD_P2_RST;
      lat_alu_p2  <= ALU_P2_RST;
    end else begin
      if (cfg_we) begin
        unique case (cfg_idx)
          CFG_READY_P1: lat_p1      <= cfg_wdata;
          CFG_LOAD_P2:  lat_load_p2 <= cfg_wdata;
          CFG_ALU_P2:   lat_alu_p2  <= cfg_wdata;
          default: begin
          end
        endcase
      end
      if (issue_fire) begin
        s1_valid <= 1'b1;
      end else if (e_fire) begin
        s1_valid <= 1'b0;
      end
      pend_valid <= e_fire && dual;
      if (e_fire) begin
        stat_valid <= 1'b1;
        cnext_p1   <= cnext_p1_next;
        cnext_p2   <= cnext_p2_next;
        hz_p1      <= res.hazards_p1;
        hz_p2      <= res.hazards_p2;
        one_p1     <= res.one_cycle_p1;
        two_p1     <= res.two_cycle_p1;
        one_p2     <= res.one_cycle_p2;
        two_p2     <= res.two_cycle_p2;
      end else if (stat_ready) begin
        stat_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (issue_fire) begin
      s1 <= issue;
    end
    if (e_fire) begin
      stat <= res;
    end
    if (e_fire && dual) begin
      pend_regno  <= s1.dst_b;
      pend_rdy.p1 <= rdy_p1_new;
      pend_rdy.p2 <= rdy_p2_new;
    end
  end

  // the deferred write cycle never overlaps a check
  `RHSS_ASSERT_NOW(a_pend_alone, pend_valid, !s1_valid && !e_fire)
  `RHSS_ASSERT_NEXT(a_dual_pends, e_fire && dual, pend_valid)
  `RHSS_ASSERT_NEXT(a_fire_shows, e_fire, stat_valid)

endmodule
